// ===== rtl/ledmap_pkg.sv =====
// ----------------------------------------------------------------------------
// ledmap_pkg
// Shared types, register indexes and the string rollover helper for the
// LED raster address mapper.
// ----------------------------------------------------------------------------
`default_nettype none

package ledmap_pkg;

  // Configuration register indexes
  typedef enum logic [3:0] {
    CFG_WRAP_MODE         = 4'd0,
    CFG_RASTER_WIDTH      = 4'd1,
    CFG_CHAIN_RUN         = 4'd2,
    CFG_START_STRING      = 4'd3,
    CFG_POS_BASE          = 4'd4,
    CFG_FIRST_BOARD       = 4'd5,
    CFG_STRINGS_PER_BOARD = 4'd6,
    CFG_STRING_LENGTH     = 4'd7
  } cfg_idx_t;

  typedef enum logic [1:0] {
    WRAP_NONE   = 2'd0,
    WRAP_ZIGZAG = 2'd1,
    WRAP_CLIP   = 2'd2,
    WRAP_CHAIN  = 2'd3
  } wrap_mode_t;

  localparam logic [6:0] MAX_STRINGS = 7'd64;

  // Physical address of one LED string
  typedef struct packed {
    logic [3:0] brd;
    logic [5:0] str;
  } addr_t;

  // Advance to the next string; last string rolls to string 0 of next board,
  // last board wraps to board 0.
  function automatic addr_t next_string(addr_t cur, logic [6:0] spb, logic [4:0] bcnt);
    logic [6:0] limit;
    logic [6:0] s;
    logic [4:0] b;
    addr_t      res;
    limit = (spb > MAX_STRINGS) ? MAX_STRINGS : spb;
    s     = {1'b0, cur.str} + 7'd1;
    b     = {1'b0, cur.brd};
    if (s >= limit) begin
      s = '0;
      b = b + 5'd1;
      if (b >= bcnt) begin
        b = '0;
      end
    end
    res.str = s[5:0];
    res.brd = b[3:0];
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/led_raster_address_mapper_core.sv =====
// ----------------------------------------------------------------------------
// led_raster_address_mapper_core
// Maps raster pixels, walked in row-major order, to board / string / position
// LED addresses in one of four wrap modes (none, zigzag, clip, chain).
// ----------------------------------------------------------------------------
// The result register sets result valid in the cycle after an input is accepted.
// Throughput: 1 item per cycle while results are taken; one combinational pass (a
//   16x16 multiply in zigzag mode) between the walk state and the result register.
// Input is taken whenever the result register is empty or drained this cycle.
// Reset (rst_n low, synchronous) clears the walk state and the result valid
//   and loads the configuration defaults; no clearing pass is needed.
`default_nettype none

module led_raster_address_mapper_core #(
  parameter int BOARD_COUNT = 4           // boards in the wrap ring, 1..16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,

  // Input items
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,      // [0] first_pixel, [7:1] zero

  // Result items
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,     // [3:0] board_number, [9:4] string_number,
                                          // [25:10] led_position, [31:26] zero

  // Configuration writes
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [3:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  localparam logic [4:0] BoardCnt = 5'(BOARD_COUNT);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  ledmap_pkg::wrap_mode_t wrap_mode_r;
  logic [13:0] raster_width_r;
  logic [15:0] chain_run_r;
  logic [5:0]  start_string_r;
  logic [15:0] pos_base_r;
  logic [3:0]  first_board_r;
  logic [6:0]  strings_per_board_r;
  logic [15:0] string_length_r;

  // Config is always accepted; the user must write only while the block is idle, the block itself does not enforce it.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wrap_mode_r         <= ledmap_pkg::WRAP_NONE;
      raster_width_r      <= 14'd1;
      chain_run_r         <= '0;
      start_string_r      <= '0;
      pos_base_r          <= '0;
      first_board_r       <= '0;
      strings_per_board_r <= 7'd32;
      string_length_r     <= 16'd1;
    end else if (cfg_valid) begin
      unique case (ledmap_pkg::cfg_idx_t'(cfg_index))
        ledmap_pkg::CFG_WRAP_MODE:
          wrap_mode_r <= ledmap_pkg::wrap_mode_t'(cfg_data[1:0]);
        ledmap_pkg::CFG_RASTER_WIDTH:      raster_width_r      <= cfg_data[13:0];
        ledmap_pkg::CFG_CHAIN_RUN:         chain_run_r         <= cfg_data;
        ledmap_pkg::CFG_START_STRING:      start_string_r      <= cfg_data[5:0];
        ledmap_pkg::CFG_POS_BASE:          pos_base_r          <= cfg_data;
        ledmap_pkg::CFG_FIRST_BOARD:       first_board_r       <= cfg_data[3:0];
        ledmap_pkg::CFG_STRINGS_PER_BOARD: strings_per_board_r <= cfg_data[6:0];
        ledmap_pkg::CFG_STRING_LENGTH:     string_length_r     <= cfg_data;
        default: ;                         // unused indexes are dropped
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Walk state
  // --------------------------------------------------------------------------
  logic [12:0]       column_count_r, column_count_nxt;
  logic [15:0]       string_pixel_count_r, string_pixel_count_nxt;
  ledmap_pkg::addr_t cur_addr_r, cur_addr_nxt;
  logic [15:0]       row_wrap_count_r, row_wrap_count_nxt;

  // Result register
  logic        out_valid_r;
  logic [31:0] out_data_r, out_data_nxt;

  logic in_accept;
  assign in_tready = !out_valid_r || out_tready;
  assign in_accept = in_tvalid && in_tready;

  // --------------------------------------------------------------------------
  // Address computation for one pixel
  // --------------------------------------------------------------------------
  logic              first_pixel;
  logic [12:0]       col0;
  logic [12:0]       col1;
  logic [15:0]       spc0;          // pixel count after restart
  logic [15:0]       spc_map;       // pixel count after clip rollover
  logic [15:0]       spc_inc;
  logic [15:0]       rwc0;
  logic [15:0]       rwc_row;       // row counter after row start
  logic [15:0]       rwc_map;
  ledmap_pkg::addr_t addr0;
  ledmap_pkg::addr_t addr_map;      // address reported for this pixel
  ledmap_pkg::addr_t addr_roll;
  logic [15:0]       run_len;
  logic [15:0]       w16;
  logic [15:0]       row_mult;      // 2r - 1
  logic [15:0]       zig_prod;
  logic [15:0]       offset;
  logic [15:0]       led_pos;

  assign first_pixel = in_tdata[0];
  assign w16         = {2'b00, raster_width_r};
  assign run_len     = (chain_run_r != 16'd0) ? chain_run_r : string_length_r;

  // Zigzag: W*r + W*(r-1) = W*(2r-1), all modulo 2^16
  assign row_mult = {rwc_row[14:0], 1'b0} - 16'd1;
  assign zig_prod = w16 * row_mult;

  always_comb begin
    // restart loads the start address and clears the counters
    col0  = first_pixel ? 13'd0 : column_count_r;
    spc0  = first_pixel ? 16'd0 : string_pixel_count_r;
    rwc0  = first_pixel ? 16'd0 : row_wrap_count_r;
    addr0 = cur_addr_r;
    if (first_pixel) begin
      addr0.str = start_string_r;
      addr0.brd = first_board_r;
    end

    // row counter: zigzag counts rows, other row modes hold it at zero
    rwc_row = rwc0;
    if (wrap_mode_r != ledmap_pkg::WRAP_CHAIN && col0 == 13'd0) begin
      rwc_row = (wrap_mode_r == ledmap_pkg::WRAP_ZIGZAG) ? rwc0 + 16'd1 : 16'd0;
    end

    // clip: a full row moves to the next string before mapping
    spc_map  = spc0;
    rwc_map  = rwc_row;
    addr_map = addr0;
    if (wrap_mode_r == ledmap_pkg::WRAP_CLIP && spc0 >= w16) begin
      spc_map  = '0;
      rwc_map  = '0;
      addr_map = ledmap_pkg::next_string(addr0, strings_per_board_r, BoardCnt);
    end

    // even zigzag rows run backward
    if (wrap_mode_r == ledmap_pkg::WRAP_ZIGZAG && !rwc_row[0]) begin
      offset = zig_prod - spc0 - 16'd1;
    end else begin
      offset = spc_map;
    end
    led_pos = offset + pos_base_r;

    // advance along the string, roll over when full or wrapped
    spc_inc   = spc_map + 16'd1;
    addr_roll = ledmap_pkg::next_string(addr_map, strings_per_board_r, BoardCnt);
    string_pixel_count_nxt = spc_inc;
    row_wrap_count_nxt     = rwc_map;
    cur_addr_nxt           = addr_map;
    if (wrap_mode_r == ledmap_pkg::WRAP_CHAIN) begin
      if (spc_inc >= run_len || spc_inc == 16'd0) begin
        string_pixel_count_nxt = '0;
        cur_addr_nxt           = addr_roll;
      end
    end else if (spc_inc >= string_length_r || spc_inc == 16'd0) begin
      string_pixel_count_nxt = '0;
      row_wrap_count_nxt     = '0;
      cur_addr_nxt           = addr_roll;
    end

    // column within the row
    col1             = col0 + 13'd1;
    column_count_nxt = ({1'b0, col1} >= raster_width_r) ? 13'd0 : col1;

    out_data_nxt = {6'd0, led_pos, addr_map.str, addr_map.brd};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      column_count_r       <= '0;
      string_pixel_count_r <= '0;
      cur_addr_r           <= '0;
      row_wrap_count_r     <= '0;
    end else if (in_accept) begin
      column_count_r       <= column_count_nxt;
      string_pixel_count_r <= string_pixel_count_nxt;
      cur_addr_r           <= cur_addr_nxt;
      row_wrap_count_r     <= row_wrap_count_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Result register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_accept) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire

// ===== rtl/ledmap_chk.sv =====
// ----------------------------------------------------------------------------
// ledmap_chk
// Port-level checks for the LED raster address mapper, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ledmap_chk (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [31:0] out_tdata
);

  // held result stays put until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // every accepted item shows a result on the next cycle
  a_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> out_tvalid)
    else $error("result missing after accept");

  // input side is open whenever the result slot is free or draining
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == (!out_tvalid || out_tready))
    else $error("input ready does not follow result slot");

  // reset empties the result register
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind led_raster_address_mapper_core ledmap_chk u_ledmap_chk (.*);

`default_nettype wire

// ===== bench/led_map_checker.sv =====
// ----------------------------------------------------------------------------
// led_map_checker
// Watches the pixel, address and register channels of the LED raster address
// mapper, predicts each board / string / position address from its own copy
// of the walk state and settings, and counts mismatches.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module led_map_checker #(
  parameter int BOARD_COUNT = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [31:0] out_tdata,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [3:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int          fail_count,
  output int          pending
);

  // Same layout as out_tdata[25:0]
  typedef struct packed {
    logic [15:0] led_pos;
    logic [5:0]  string_num;
    logic [3:0]  board_num;
  } led_addr_t;

  // settings
  ledmap_pkg::wrap_mode_t mode;
  logic [13:0] width;
  logic [15:0] chain_run;
  logic [5:0]  start_str;
  logic [15:0] start_pix;
  logic [3:0]  first_brd;
  logic [6:0]  spb;
  logic [15:0] str_len;

  // walk state
  logic [12:0] col;
  logic [15:0] str_pix;
  logic [5:0]  cur_str;
  logic [3:0]  cur_brd;
  logic [15:0] row_cnt;

  led_addr_t addr_q[$];

  function automatic void advance_string();
    logic [6:0] limit;
    logic [6:0] s;
    logic [4:0] b;
    limit = (spb > ledmap_pkg::MAX_STRINGS) ? ledmap_pkg::MAX_STRINGS : spb;
    s = {1'b0, cur_str} + 7'd1;
    if (s >= limit) begin
      s = '0;
      b = {1'b0, cur_brd} + 5'd1;
      if (b >= BOARD_COUNT) begin
        b = '0;
      end
      cur_brd = b[3:0];
    end
    cur_str = s[5:0];
  endfunction

  function automatic led_addr_t map_pixel(logic restart);
    logic [15:0] run;
    logic [31:0] w;
    logic [31:0] r;
    logic [31:0] offset;
    led_addr_t   a;
    w = {18'b0, width};
    if (restart) begin
      col     = '0;
      str_pix = '0;
      row_cnt = '0;
      cur_str = start_str;
      cur_brd = first_brd;
    end
    if (mode == ledmap_pkg::WRAP_CHAIN) begin
      run = (chain_run != 16'd0) ? chain_run : str_len;
      a.board_num  = cur_brd;
      a.string_num = cur_str;
      a.led_pos    = str_pix + start_pix;
      str_pix = str_pix + 16'd1;
      if (str_pix >= run || str_pix == 16'd0) begin
        str_pix = '0;
        advance_string();
      end
    end else begin
      if (col == 13'd0) begin
        row_cnt = (mode == ledmap_pkg::WRAP_ZIGZAG) ? row_cnt + 16'd1 : 16'd0;
      end
      if (mode == ledmap_pkg::WRAP_ZIGZAG) begin
        // even rows run backward
        if (!row_cnt[0]) begin
          r = {16'b0, row_cnt};
          offset = w * r - ({16'b0, str_pix} + 32'd1) + w * (r - 32'd1);
        end else begin
          offset = {16'b0, str_pix};
        end
      end else begin
        if (mode == ledmap_pkg::WRAP_CLIP && {16'b0, str_pix} >= w) begin
          str_pix = '0;
          row_cnt = '0;
          advance_string();
        end
        offset = {16'b0, str_pix};
      end
      a.board_num  = cur_brd;
      a.string_num = cur_str;
      a.led_pos    = offset[15:0] + start_pix;
      str_pix = str_pix + 16'd1;
      if (str_pix >= str_len || str_pix == 16'd0) begin
        str_pix = '0;
        row_cnt = '0;
        advance_string();
      end
    end
    col = col + 13'd1;
    if ({19'b0, col} >= w) begin
      col = '0;
    end
    return a;
  endfunction

  always @(posedge clk) begin : watch
    led_addr_t want;
    led_addr_t got;
    if (!rst_n) begin
      mode      = ledmap_pkg::WRAP_NONE;
      width     = 14'd1;
      chain_run = '0;
      start_str = '0;
      start_pix = '0;
      first_brd = '0;
      spb       = 7'd32;
      str_len   = 16'd1;
      col       = '0;
      str_pix   = '0;
      cur_str   = '0;
      cur_brd   = '0;
      row_cnt   = '0;
      addr_q.delete();
    end else begin
      // results first: anything leaving now came from an earlier pixel
      if (out_tvalid && out_tready) begin
        got = out_tdata[25:0];
        if (addr_q.size() == 0) begin
          $error("result item 0x%h with no pixel pending", out_tdata);
          fail_count++;
        end else begin
          want = addr_q.pop_front();
          if (got.board_num != want.board_num) begin
            $error("board_number: expected %0d, actual %0d", want.board_num, got.board_num);
            fail_count++;
          end
          if (got.string_num != want.string_num) begin
            $error("string_number: expected %0d, actual %0d",
                   want.string_num, got.string_num);
            fail_count++;
          end
          if (got.led_pos != want.led_pos) begin
            $error("led_position: expected %0d, actual %0d", want.led_pos, got.led_pos);
            fail_count++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (ledmap_pkg::cfg_idx_t'(cfg_index))
          ledmap_pkg::CFG_WRAP_MODE:
            mode = ledmap_pkg::wrap_mode_t'(cfg_data[1:0]);
          ledmap_pkg::CFG_RASTER_WIDTH:      width     = cfg_data[13:0];
          ledmap_pkg::CFG_CHAIN_RUN:         chain_run = cfg_data;
          ledmap_pkg::CFG_START_STRING:      start_str = cfg_data[5:0];
          ledmap_pkg::CFG_POS_BASE:          start_pix = cfg_data;
          ledmap_pkg::CFG_FIRST_BOARD:       first_brd = cfg_data[3:0];
          ledmap_pkg::CFG_STRINGS_PER_BOARD: spb       = cfg_data[6:0];
          ledmap_pkg::CFG_STRING_LENGTH:     str_len   = cfg_data;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        addr_q.push_back(map_pixel(in_tdata[0]));
      end
    end
    pending = addr_q.size();
  end

endmodule

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives pixel items and register writes into the LED raster address mapper
// through all four wrap modes, lets led_map_checker predict and compare every
// address, and reports the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

  localparam int BOARDS        = 4;
  localparam int RANDOM_PIXELS = 400;   // random part stops past this many items
  localparam int STEADY_RUN    = 60;    // gap-free items on both sides
  localparam int LONG_HOLD     = 120;   // cycles the sink refuses results once

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;      // [0] first_pixel, [7:1] zero
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;     // [3:0] board_number, [9:4] string_number,
                              // [25:10] led_position, [31:26] zero
  logic        cfg_valid;
  logic        cfg_ready;
  logic [3:0]  cfg_index;
  logic [15:0] cfg_data;

  int fail_count;
  int pending;                // addresses predicted but not yet seen

  bit steady;                 // set: neither side inserts gaps
  bit hold_req;               // set by the source, taken by the sink

  led_raster_address_mapper_core #(.BOARD_COUNT(BOARDS)) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  led_map_checker #(.BOARD_COUNT(BOARDS)) u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop well past the slowest legal run
  initial begin : watchdog
    #2_000_000;
    $display("led_raster_address_mapper_core verification failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Helpers. All of them are entered and left on a falling edge; a valid is
  // left high between items so it never drops and rises within one step.
  // ---------------------------------------------------------------------------

  // One register write; cfg_valid stays high for a following write.
  task automatic write_reg(input ledmap_pkg::cfg_idx_t idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Full register set; only called with the mapper idle.
  task automatic configure(input ledmap_pkg::wrap_mode_t mode_sel,
                           input logic [13:0] width,
                           input logic [15:0] chain,
                           input logic [5:0]  sstr,
                           input logic [15:0] spix,
                           input logic [3:0]  fbrd,
                           input logic [6:0]  spb,
                           input logic [15:0] slen);
    write_reg(ledmap_pkg::CFG_WRAP_MODE,         16'(mode_sel));
    write_reg(ledmap_pkg::CFG_RASTER_WIDTH,      16'(width));
    write_reg(ledmap_pkg::CFG_CHAIN_RUN,         chain);
    write_reg(ledmap_pkg::CFG_START_STRING,      16'(sstr));
    write_reg(ledmap_pkg::CFG_POS_BASE,          spix);
    write_reg(ledmap_pkg::CFG_FIRST_BOARD,       16'(fbrd));
    write_reg(ledmap_pkg::CFG_STRINGS_PER_BOARD, 16'(spb));
    write_reg(ledmap_pkg::CFG_STRING_LENGTH,     slen);
    cfg_valid <= 1'b0;
  endtask

  // A run of pixel items: the first one restarts the walk or not as asked,
  // later ones restart with the given percentage.
  task automatic send_pixels(input int count, input bit restart_first,
                             input int restart_pct);
    for (int k = 0; k < count; k++) begin
      while (!steady && $urandom_range(99) < 22) begin
        in_tvalid <= 1'b0;
        @(negedge clk);
      end
      in_tvalid <= 1'b1;
      in_tdata  <= {7'b0, (k == 0) ? restart_first : ($urandom_range(99) < restart_pct)};
      @(posedge clk);
      while (!in_tready) @(posedge clk);
      @(negedge clk);
    end
    in_tvalid <= 1'b0;
  endtask

  // Source paused: wait for every predicted address to come out.
  task automatic await_all_addresses();
    do @(negedge clk); while (pending != 0);
  endtask

  // Mostly short lengths so strings and boards roll over often.
  function automatic logic [15:0] pick_length();
    case ($urandom_range(9))
      0:       return 16'd0;
      1:       return 16'($urandom);
      default: return 16'($urandom_range(1, 12));
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Result sink: random back-pressure, plus one long hold-off on request.
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int hold;
    hold = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold     = LONG_HOLD;
        hold_req = 1'b0;
      end
      if (hold > 0) begin
        hold--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= steady || ($urandom_range(99) >= 22);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Pixel source and verdict
  // ---------------------------------------------------------------------------
  initial begin : pixel_source
    int          sent;
    int          phase;
    int          burst;
    logic [13:0] width_pick;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    steady    = 1'b0;
    hold_req  = 1'b0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // --- directed part ---
    // walk from the reset state before any restart, then restart
    send_pixels(2, 1'b0, 0);
    await_all_addresses();
    send_pixels(1, 1'b1, 0);
    await_all_addresses();

    // zigzag, three columns: odd rows forward, even rows backward; board out
    // of range, top string, positions wrapping through the position base
    configure(ledmap_pkg::WRAP_ZIGZAG, 14'd3, 16'hFFFF, 6'd63, 16'hFFFF, 4'd15, 7'd64,
              16'hFFFF);
    send_pixels(8, 1'b1, 0);
    await_all_addresses();

    // clip, two per row; start string and board beyond their ranges
    configure(ledmap_pkg::WRAP_CLIP, 14'd2, 16'd0, 6'd40, 16'd0, 4'd9, 7'd8, 16'd5);
    send_pixels(6, 1'b1, 0);
    await_all_addresses();

    // chain with zero effective length, zero strings per board, zero width
    configure(ledmap_pkg::WRAP_CHAIN, 14'd0, 16'd0, 6'd0, 16'd100, 4'd2, 7'd0, 16'd0);
    send_pixels(4, 1'b1, 0);
    await_all_addresses();

    // mode change without restart; strings per board above 64, widest raster
    configure(ledmap_pkg::WRAP_NONE, 14'h3FFF, 16'd2, 6'd63, 16'd1, 4'd3, 7'd127, 16'd3);
    send_pixels(4, 1'b0, 0);
    await_all_addresses();

    // zigzag rows with short strings, gap-free on both sides
    configure(ledmap_pkg::WRAP_ZIGZAG, 14'd5, 16'd0, 6'd1, 16'd7, 4'd0, 7'd64, 16'd9);
    steady = 1'b1;
    send_pixels(STEADY_RUN, 1'b1, 0);
    await_all_addresses();
    steady = 1'b0;

    // --- random part: new settings per phase, mostly restarted walks ---
    sent  = 0;
    phase = 0;
    while (sent < RANDOM_PIXELS) begin
      case ($urandom_range(9))
        0:       width_pick = '0;
        1:       width_pick = 14'($urandom_range(0, 16383));
        2:       width_pick = 14'd8192;
        default: width_pick = 14'($urandom_range(1, 12));
      endcase
      configure(ledmap_pkg::wrap_mode_t'($urandom_range(0, 3)),
                width_pick,
                ($urandom_range(3) == 0) ? pick_length() : 16'($urandom_range(0, 7)),
                6'(($urandom_range(99) < 70) ? $urandom_range(0, 7) : $urandom_range(0, 63)),
                ($urandom_range(1) == 0) ? 16'($urandom) : 16'($urandom_range(0, 15)),
                4'(($urandom_range(99) < 85) ? $urandom_range(0, 3) : $urandom_range(0, 15)),
                7'(($urandom_range(99) < 80) ? $urandom_range(1, 6) : $urandom_range(0, 127)),
                pick_length());
      // one phase runs into a long sink hold-off so the input backs up
      if (phase == 2) begin
        hold_req = 1'b1;
      end
      burst = (phase == 2) ? 40 : $urandom_range(10, 50);
      send_pixels(burst, $urandom_range(99) < 80, 5);
      await_all_addresses();
      sent += burst;
      phase++;
    end

    // spare cycles at the end catch stray results
    repeat (4) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("led_raster_address_mapper_core verification clean");
    end else begin
      $display("led_raster_address_mapper_core verification failed");
    end
    $finish;
  end

endmodule
